### sv/cdss_pkg.sv
// Shared constants, types and status codes of the call duration shadow stack.
package cdss_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int CLASS_W     = 32;
    localparam int SEL_W       = 32;
    localparam int RA_W        = 64;
    localparam int TS_W        = 27;
    localparam int DEPTH_W     = 7;
    localparam int MAXD_W      = 8;
    localparam int CMP_W       = (ADDR_W > MAXD_W) ? ADDR_W : MAXD_W;

    localparam logic [TS_W:0] WRAP_US = (TS_W + 1)'(100000000);

    localparam int IN_DATA_W   = 160;
    localparam int OUT_DATA_W  = 168;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 27;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRACE_ENABLED = 2'd0,
        CFG_TIMING_THREAD = 2'd1,
        CFG_MIN_COST_US   = 2'd2,
        CFG_MAX_DEPTH     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // One stack frame apart from its start time.
    typedef struct packed {
        logic [RA_W-1:0]    return_addr;
        logic [SEL_W-1:0]   selector_id;
        logic [CLASS_W-1:0] class_id;
    } t_frame;

    // Write side of the frame store.
    typedef struct packed {
        logic              wr_en;
        logic              time_wr_en;
        logic [ADDR_W-1:0] addr;
    } t_store_wr;

endpackage

### sv/cdss_frame_store.sv
// Frame memory and start time memory of the shadow stack, registered read.
module cdss_frame_store
    import cdss_pkg::*;
(
    input  logic              i_clk,
    input  t_store_wr         i_wr,
    input  t_frame            i_wr_frame,
    input  logic [TS_W-1:0]   i_wr_time,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_frame            o_rd_frame,
    output logic [TS_W-1:0]   o_rd_time
);

    t_frame          r_frame_mem [STACK_DEPTH];
    logic [TS_W-1:0] r_time_mem  [STACK_DEPTH];
    t_frame          r_rd_frame;
    logic [TS_W-1:0] r_rd_time;

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en) begin
            r_frame_mem[i_wr.addr] <= i_wr_frame;
        end
        if (i_rd_en) begin
            r_rd_frame <= r_frame_mem[i_rd_addr];
        end
    end

    // Start time is kept separately: an untimed call leaves the old value.
    always_ff @(posedge i_clk) begin
        if (i_wr.time_wr_en) begin
            r_time_mem[i_wr.addr] <= i_wr_time;
        end
        if (i_rd_en) begin
            r_rd_time <= r_time_mem[i_rd_addr];
        end
    end

    assign o_rd_frame = r_rd_frame;
    assign o_rd_time  = r_rd_time;

endmodule

### sv/call_duration_shadow_stack.sv
// Shadow call stack that times each call and emits trace records on return.
// A call word (tuser 0) pushes class, selector, return address and, when
// tracing is on for the timed thread, its timestamp; a return word (tuser 1)
// pops the top frame and answers with its return address and, if the call
// outlasted min_cost_us at a depth of at most max_depth, a trace record.
// Every input word gives exactly one output word. A call passes through
// S_EVAL into the output register and a return through S_READ and S_EVAL:
// the frame memories have a registered read and the elapsed time is
// computed in a stage of its own. The block takes the next word once the
// previous result sits in the output register, so no word is taken while
// another is in flight; a full output register stalls the input only when
// a second result is ready. Overflow and underflow are reported in status;
// the stack is left as it was.
module call_duration_shadow_stack
    import cdss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [31:0] class_id, [63:32] selector_id, [127:64] return_addr,
    // [154:128] timestamp_us, [159:155] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [0] cmd
    input  logic                  i_s_axis_tuser,
    // output stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [1:0] status, [65:2] popped_return_addr, [97:66] record_class,
    // [129:98] record_selector, [136:130] record_depth,
    // [163:137] record_cost_us, [167:164] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // [0] record_valid
    output logic                  o_m_axis_tuser
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EVAL = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        K_CALL = 2'd0,
        K_OVF  = 2'd1,
        K_UNF  = 2'd2,
        K_POP  = 2'd3
    } t_kind;

    // configuration registers
    logic              r_trace_enabled;
    logic              r_timing_thread;
    logic [TS_W-1:0]   r_min_cost;
    logic [MAXD_W-1:0] r_max_depth;

    t_state            r_state;
    t_kind             r_kind;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_top;
    logic [TS_W-1:0]   r_now;
    logic              r_timed;
    logic [TS_W-1:0]   r_cost;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_user;

    // input word fields
    logic              in_cmd;
    t_frame            in_frame;
    logic [TS_W-1:0]   in_ts;

    logic              accept;
    logic              timed;
    logic              full;
    logic              empty;
    t_store_wr         store_wr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    t_frame            rd_frame;
    logic [TS_W-1:0]   rd_time;

    logic [TS_W:0]     now_ext;
    logic [TS_W:0]     cost_wide;
    logic              out_load;
    logic              rec_hit;
    t_status           res_status;
    logic [RA_W-1:0]   res_ra;
    logic [CLASS_W-1:0] res_class;
    logic [SEL_W-1:0]  res_sel;
    logic [DEPTH_W-1:0] res_depth;
    logic [TS_W-1:0]   res_cost;

    assign in_cmd               = i_s_axis_tuser;
    assign in_frame.class_id    = i_s_axis_tdata[31:0];
    assign in_frame.selector_id = i_s_axis_tdata[63:32];
    assign in_frame.return_addr = i_s_axis_tdata[127:64];
    assign in_ts                = i_s_axis_tdata[154:128];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign timed           = r_trace_enabled && r_timing_thread;
    assign full            = (r_count == CNT_W'(STACK_DEPTH));
    assign empty           = (r_count == '0);

    always_comb begin
        store_wr.wr_en      = accept && !in_cmd && !full;
        store_wr.time_wr_en = accept && !in_cmd && !full && timed;
        store_wr.addr       = r_count[ADDR_W-1:0];
    end

    assign rd_en   = accept && in_cmd && !empty;
    assign rd_addr = ADDR_W'(r_count - CNT_W'(1));

    cdss_frame_store u_store (
        .i_clk      (i_clk),
        .i_wr       (store_wr),
        .i_wr_frame (in_frame),
        .i_wr_time  (in_ts),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_frame (rd_frame),
        .o_rd_time  (rd_time)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trace_enabled <= 1'b1;
            r_timing_thread <= 1'b1;
            r_min_cost      <= TS_W'(1000);
            r_max_depth     <= MAXD_W'(3);
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_TRACE_ENABLED: r_trace_enabled <= i_cfg_wdata[0];
                CFG_TIMING_THREAD: r_timing_thread <= i_cfg_wdata[0];
                CFG_MIN_COST_US:   r_min_cost      <= i_cfg_wdata[TS_W-1:0];
                CFG_MAX_DEPTH:     r_max_depth     <= i_cfg_wdata[MAXD_W-1:0];
                default: ;
            endcase
        end
    end

    // elapsed time, adding the wrap period when the clock went round
    assign now_ext   = (r_now < rd_time) ? ({1'b0, r_now} + WRAP_US) : {1'b0, r_now};
    assign cost_wide = now_ext - {1'b0, rd_time};

    assign out_load = (r_state == S_EVAL) && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (!in_cmd) begin
                            if (!full) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                            r_state <= S_EVAL;
                        end else if (empty) begin
                            r_state <= S_EVAL;
                        end else begin
                            r_count <= r_count - CNT_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // per-word payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_top   <= rd_addr;
            r_now   <= in_ts;
            r_timed <= timed;
            if (!in_cmd) begin
                r_kind <= full ? K_OVF : K_CALL;
            end else begin
                r_kind <= empty ? K_UNF : K_POP;
            end
        end
        if (r_state == S_READ) begin
            r_cost <= cost_wide[TS_W-1:0];
        end
    end

    assign rec_hit = (r_kind == K_POP) && r_timed && (r_cost > r_min_cost)
                     && (CMP_W'(r_top) <= CMP_W'(r_max_depth));

    always_comb begin
        res_status = ST_OK;
        res_ra     = '0;
        case (r_kind)
            K_CALL: res_status = ST_OK;
            K_OVF:  res_status = ST_OVERFLOW;
            K_UNF:  res_status = ST_UNDERFLOW;
            K_POP:  res_ra     = rd_frame.return_addr;
            default: res_status = ST_OK;
        endcase
        res_class = rec_hit ? rd_frame.class_id : '0;
        res_sel   = rec_hit ? rd_frame.selector_id : '0;
        res_depth = rec_hit ? DEPTH_W'(r_top) : '0;
        res_cost  = rec_hit ? r_cost : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {4'b0, res_cost, res_depth, res_sel, res_class, res_ra,
                           res_status};
            r_out_user <= rec_hit;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_record_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[1:0] == ST_OK))
        else $error("trace record with error status");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_axis_tready)
        else $error("word taken while previous one still in flight");

    a_pop_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ($past(rd_en) && (r_kind == K_POP)))
        else $error("read stage without a pop");
`endif

endmodule
